// ----- design/trme_pkg.sv -----
// Shared types, codes and constants of the register machine executor.
package trme_pkg;

	localparam int REG_COUNT_DEF  = 32;
	localparam int LINE_COUNT_DEF = 128;
	localparam int QUEUE_DEPTH    = 2;

	// Instruction kind codes as they arrive from the host.
	localparam logic [2:0] KIND_PUT   = 3'd0;
	localparam logic [2:0] KIND_ADD   = 3'd1;
	localparam logic [2:0] KIND_JEQ   = 3'd2;
	localparam logic [2:0] KIND_PRINT = 3'd3;
	localparam logic [2:0] KIND_JUMP  = 3'd4;
	localparam logic [2:0] KIND_HALT  = 3'd5;
	// Spare codes with no operation of their own; the line simply advances.
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	typedef enum logic [2:0] {
		OP_PUT,
		OP_ADD,
		OP_JEQ,
		OP_PRINT,
		OP_JUMP,
		OP_HALT,
		OP_NOP
	} op_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  first_reg;
		logic [4:0]  second_reg;
		logic [30:0] immediate;
		logic [6:0]  target_line;
	} instr_t;

	typedef struct packed {
		logic [7:0]         next_line;
		logic               print_valid;
		logic signed [31:0] print_value;
		logic               halted;
	} result_t;

	// Decoded instruction: register slots already reduced, target already clamped.
	typedef struct packed {
		op_t         op;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [30:0] imm;
		logic [6:0]  target;
	} dec_t;

endpackage

// ----- design/trme_fifo.sv -----
// Small flop-based queue used between the front and back and on the result side.
module trme_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T                store_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- design/trme_front.sv -----
// Front end: takes instruction beats, decodes kind, reduces register numbers, clamps targets.
module trme_front #(
	parameter int REG_COUNT  = trme_pkg::REG_COUNT_DEF,
	parameter int LINE_COUNT = trme_pkg::LINE_COUNT_DEF
) (
	input  trme_pkg::instr_t instr,
	output trme_pkg::dec_t   dec
);
	import trme_pkg::*;

	// Register number modulo the register count, worked out at elaboration.
	logic [4:0] slot_lut [32];

	for (genvar g = 0; g < 32; g++) begin : g_slot
		assign slot_lut[g] = 5'(g % REG_COUNT);
	end

	always_comb begin
		dec.ra  = slot_lut[instr.first_reg];
		dec.rb  = slot_lut[instr.second_reg];
		dec.imm = instr.immediate;
		if (32'(instr.target_line) >= 32'(LINE_COUNT)) begin
			dec.target = 7'(LINE_COUNT);
		end else begin
			dec.target = instr.target_line;
		end
		case (instr.kind)
			KIND_PUT:   dec.op = OP_PUT;
			KIND_ADD:   dec.op = OP_ADD;
			KIND_JEQ:   dec.op = OP_JEQ;
			KIND_PRINT: dec.op = OP_PRINT;
			KIND_JUMP:  dec.op = OP_JUMP;
			KIND_HALT:  dec.op = OP_HALT;
			default:    dec.op = OP_NOP;
		endcase
	end

endmodule

// ----- design/trme_back.sv -----
// Back end: register file read stage, then execute stage that updates state and emits results.
module trme_back #(
	parameter int REG_COUNT  = trme_pkg::REG_COUNT_DEF,
	parameter int LINE_COUNT = trme_pkg::LINE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  trme_pkg::dec_t    dec,
	input  logic              dec_empty,
	output logic              dec_pop,
	output trme_pkg::result_t res,
	output logic              res_push,
	input  logic              res_full
);
	import trme_pkg::*;

	localparam int IW = $clog2(REG_COUNT);
	localparam int LW = $clog2(LINE_COUNT + 1);

	logic [31:0]          rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0] rf_vld_q;

	logic                 s2_vld_q;
	op_t                  op_s2;
	logic [IW-1:0]        ra_s2;
	logic [IW-1:0]        rb_s2;
	logic [30:0]          imm_s2;
	logic [LW-1:0]        tgt_s2;
	logic [31:0]          rda_s2;
	logic [31:0]          rdb_s2;
	logic                 rda_vld_s2;
	logic                 rdb_vld_s2;

	logic                 wr_vld_q;
	logic [IW-1:0]        wr_addr_q;
	logic [31:0]          wr_data_q;

	logic [LW-1:0]        line_q;
	logic                 stopped_q;

	logic [IW-1:0]        ra_rd;
	logic [IW-1:0]        rb_rd;
	logic                 advance;
	logic                 take;
	logic                 fire;
	logic [31:0]          opa;
	logic [31:0]          opb;
	logic [LW-1:0]        line_inc;
	logic [LW-1:0]        next_line;
	logic                 wr_req;
	logic                 wr_en;
	logic [31:0]          wr_data;
	logic                 halt_now;
	logic                 printed;
	logic [31:0]          pval;

	assign ra_rd    = IW'(dec.ra);
	assign rb_rd    = IW'(dec.rb);
	assign fire     = s2_vld_q && !res_full;
	assign advance  = !s2_vld_q || fire;
	assign take     = advance && !dec_empty;
	assign dec_pop  = take;
	assign res_push = fire;

	// Register file: read in the first stage, written by the execute stage.
	always_ff @(posedge clk) begin
		if (take) begin
			rda_s2     <= rf_mem[ra_rd];
			rdb_s2     <= rf_mem[rb_rd];
			rda_vld_s2 <= rf_vld_q[ra_rd];
			rdb_vld_s2 <= rf_vld_q[rb_rd];
			op_s2      <= dec.op;
			ra_s2      <= ra_rd;
			rb_s2      <= rb_rd;
			imm_s2     <= dec.imm;
			tgt_s2     <= LW'(dec.target);
		end
		if (wr_en) begin
			rf_mem[rb_s2] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wr_addr_q <= rb_s2;
			wr_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q  <= '0;
			s2_vld_q  <= 1'b0;
			wr_vld_q  <= 1'b0;
			line_q    <= '0;
			stopped_q <= 1'b0;
		end else begin
			if (advance) begin
				s2_vld_q <= !dec_empty;
			end
			if (wr_en) begin
				rf_vld_q[rb_s2] <= 1'b1;
				wr_vld_q        <= 1'b1;
			end
			if (fire) begin
				line_q    <= next_line;
				stopped_q <= stopped_q || halt_now;
			end
		end
	end

	// The read in the first stage misses the write made in the same cycle; take it from
	// the last-write register instead. No other write can intervene while waiting here.
	always_comb begin
		if (wr_vld_q && wr_addr_q == ra_s2) begin
			opa = wr_data_q;
		end else begin
			opa = rda_vld_s2 ? rda_s2 : '0;
		end
		if (wr_vld_q && wr_addr_q == rb_s2) begin
			opb = wr_data_q;
		end else begin
			opb = rdb_vld_s2 ? rdb_s2 : '0;
		end
	end

	assign line_inc = (line_q == LW'(LINE_COUNT)) ? line_q : line_q + LW'(1);

	always_comb begin
		next_line = line_inc;
		wr_req    = 1'b0;
		wr_data   = '0;
		halt_now  = 1'b0;
		printed   = 1'b0;
		pval      = '0;
		if (stopped_q) begin
			next_line = line_q;
		end else begin
			case (op_s2)
				OP_PUT: begin
					wr_req  = 1'b1;
					wr_data = {1'b0, imm_s2};
				end
				OP_ADD: begin
					wr_req  = 1'b1;
					wr_data = opb + opa;
				end
				OP_JEQ: begin
					if (opa == opb) begin
						next_line = tgt_s2;
					end
				end
				OP_PRINT: begin
					printed = 1'b1;
					pval    = opa;
				end
				OP_JUMP: begin
					next_line = tgt_s2;
				end
				OP_HALT: begin
					halt_now  = 1'b1;
					next_line = line_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign wr_en = fire && wr_req;

	always_comb begin
		res.next_line   = 8'(next_line);
		res.print_valid = printed;
		res.print_value = pval;
		res.halted      = stopped_q || halt_now;
	end

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("halted flag cleared");

	a_no_write_halted: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> !wr_en)
		else $error("register write after halt");

	a_line_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		fire && stopped_q |=> line_q == $past(line_q))
		else $error("line moved after halt");

	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q <= LW'(LINE_COUNT))
		else $error("line beyond program end");

endmodule

// ----- design/tiny_register_machine_executor.sv -----
// Top level of the register machine executor: front decode, queue, back execute, result queue.
// Each instruction passes the decode queue, the register file read and the execute stage
// before its result shows on the result port.
// Throughput: one instruction per cycle while the output keeps up, set by the execute stage and the
// register-file forwarding path; full only rises when the queues back up from the output.
// Reset (arst_n, asynchronous, active low) empties both queues, sets the line to zero,
// clears the halted flag and makes every register read as zero at once; no clearing pass.
module tiny_register_machine_executor #(
	parameter int REG_COUNT  = trme_pkg::REG_COUNT_DEF,
	parameter int LINE_COUNT = trme_pkg::LINE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  trme_pkg::instr_t  instr,
	output logic              empty,
	input  logic              pop,
	output trme_pkg::result_t result
);
	import trme_pkg::*;

	dec_t    dec_in;
	dec_t    dec_head;
	logic    dec_empty;
	logic    dec_pop;
	result_t res_d;
	logic    res_push;
	logic    res_full;

	// The front decodes each accepted beat straight into the decode queue, so a beat is
	// taken whenever the queue has room.
	trme_front #(
		.REG_COUNT  (REG_COUNT),
		.LINE_COUNT (LINE_COUNT)
	) u_front (
		.instr (instr),
		.dec   (dec_in)
	);

	// The decode queue lets the front keep accepting while the back waits on the output.
	trme_fifo #(
		.T     (dec_t),
		.DEPTH (QUEUE_DEPTH)
	) u_dec_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec_in),
		.full   (full),
		.pop    (dec_pop),
		.rdata  (dec_head),
		.empty  (dec_empty)
	);

	// The back reads the register file in one stage and executes in the next, keeping
	// the current line and the halted flag.
	trme_back #(
		.REG_COUNT  (REG_COUNT),
		.LINE_COUNT (LINE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (dec_head),
		.dec_empty (dec_empty),
		.dec_pop   (dec_pop),
		.res       (res_d),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// The result queue holds finished beats until the consumer pops them.
	trme_fifo #(
		.T     (result_t),
		.DEPTH (QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_d),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
